### hdl/ctepm_pkg.sv
// Shared types, constants and tables for the complex bin to energy / phase / magnitude block.
// No dependencies; imported by every module under hdl.
`default_nettype none

package ctepm_pkg;

    localparam int DEF_SAMPLE_WIDTH  = 16;
    localparam int DEF_CORDIC_STAGES = 16;

    // Energy is always carried as unsigned Q2.30 in 32 bits.
    localparam int ENERGY_W  = 32;
    localparam int MAG_W     = 16;
    localparam int PHASE_W   = 16;
    localparam int ACC_W     = 32;
    // Digit-by-digit square root of a 32-bit energy: one result bit per step.
    localparam int SQRT_STEPS = ENERGY_W / 2;
    localparam int OUT_TDATA_W = ENERGY_W + MAG_W + PHASE_W;

    // Binary angles: 2^31 stands for pi.
    localparam logic [ACC_W-1:0] ANGLE_PLUS_HALF_PI  = 32'h4000_0000;
    localparam logic [ACC_W-1:0] ANGLE_MINUS_HALF_PI = 32'hC000_0000;
    localparam logic [ACC_W-1:0] ANGLE_ROUND_HALF    = 32'h0000_8000;

    // atan(2^-i) / pi * 2^31, truncated.
    localparam logic [ACC_W-1:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    typedef enum logic [1:0] {
        MODE_ENERGY    = 2'd0,
        MODE_PHASE     = 2'd1,
        MODE_BOTH      = 2'd2,
        MODE_MAGNITUDE = 2'd3
    } t_mode;

    // Control that travels alongside each bin through the pipeline.
    typedef struct packed {
        logic  valid;
        logic  last;
        logic  zero;
        t_mode mode;
    } t_ctl;

endpackage

`default_nettype wire

### hdl/ctepm_front.sv
// Front end: squares of both parts, energy scaling to Q2.30 and the CORDIC quadrant pre-rotation.
// Depends on ctepm_pkg. Two register stages, advanced together by i_en.
`default_nettype none

module ctepm_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_en,
    input  wire                                 i_valid,
    input  wire  signed [SAMPLE_WIDTH-1:0]      i_re,
    input  wire  signed [SAMPLE_WIDTH-1:0]      i_im,
    input  wire                                 i_last,
    input  ctepm_pkg::t_mode                    i_mode,
    output ctepm_pkg::t_ctl                     o_ctl,
    output logic signed [SAMPLE_WIDTH+2:0]      o_x,
    output logic signed [SAMPLE_WIDTH+2:0]      o_y,
    output logic [ctepm_pkg::ACC_W-1:0]         o_acc,
    output logic [ctepm_pkg::ENERGY_W-1:0]      o_energy
);
    import ctepm_pkg::*;

    localparam int XW = SAMPLE_WIDTH + 3;
    localparam int PW = 2 * SAMPLE_WIDTH;

    logic signed [PW-1:0]           sq_re;
    logic signed [PW-1:0]           sq_im;
    logic [PW-1:0]                  sum_sq;
    logic [ENERGY_W-1:0]            energy_q;
    logic signed [XW-1:0]           x_ext;
    logic signed [XW-1:0]           y_ext;

    t_ctl                           r_a_ctl;
    logic signed [SAMPLE_WIDTH-1:0] r_a_re;
    logic signed [SAMPLE_WIDTH-1:0] r_a_im;
    logic [PW-1:0]                  r_a_re2;
    logic [PW-1:0]                  r_a_im2;

    t_ctl                           n_b_ctl;
    logic signed [XW-1:0]           n_b_x;
    logic signed [XW-1:0]           n_b_y;
    logic [ACC_W-1:0]               n_b_acc;

    assign sq_re = i_re * i_re;
    assign sq_im = i_im * i_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_a_ctl.valid <= i_valid;
            r_a_ctl.last  <= i_last;
            r_a_ctl.zero  <= 1'b0;
            r_a_ctl.mode  <= i_mode;
            r_a_re        <= i_re;
            r_a_im        <= i_im;
            r_a_re2       <= sq_re;
            r_a_im2       <= sq_im;
        end
    end

    // Both squares are at most 2^(PW-2), so the sum fits PW bits.
    assign sum_sq = r_a_re2 + r_a_im2;

    generate
        if (SAMPLE_WIDTH >= 16) begin : g_scale_down
            assign energy_q = sum_sq[PW-1 -: ENERGY_W];
        end else begin : g_scale_up
            assign energy_q = {sum_sq, {(ENERGY_W-PW){1'b0}}};
        end
    endgenerate

    assign x_ext = r_a_re;
    assign y_ext = r_a_im;

    // Fold the left half plane onto the right one by a quarter turn.
    always_comb begin
        n_b_ctl      = r_a_ctl;
        n_b_ctl.zero = (r_a_re == '0) && (r_a_im == '0);
        n_b_x        = x_ext;
        n_b_y        = y_ext;
        n_b_acc      = '0;
        if (x_ext < 0) begin
            if (y_ext >= 0) begin
                n_b_x   = y_ext;
                n_b_y   = -x_ext;
                n_b_acc = ANGLE_PLUS_HALF_PI;
            end else begin
                n_b_x   = -y_ext;
                n_b_y   = x_ext;
                n_b_acc = ANGLE_MINUS_HALF_PI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.valid <= 1'b0;
        end else if (i_en) begin
            o_ctl    <= n_b_ctl;
            o_x      <= n_b_x;
            o_y      <= n_b_y;
            o_acc    <= n_b_acc;
            o_energy <= energy_q;
        end
    end

endmodule

`default_nettype wire

### hdl/ctepm_cell.sv
// One cell of the chain: one CORDIC vectoring micro-rotation and one square-root digit step.
// Depends on ctepm_pkg. Either half passes its data through when its step count is exhausted.
`default_nettype none

module ctepm_cell #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int CORDIC_STAGES = 16,
    parameter int IDX           = 0
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_en,
    input  ctepm_pkg::t_ctl                     i_ctl,
    input  wire  signed [SAMPLE_WIDTH+2:0]      i_x,
    input  wire  signed [SAMPLE_WIDTH+2:0]      i_y,
    input  wire  [ctepm_pkg::ACC_W-1:0]         i_acc,
    input  wire  [ctepm_pkg::ENERGY_W-1:0]      i_energy,
    input  wire  [ctepm_pkg::ENERGY_W-1:0]      i_rem,
    input  wire  [ctepm_pkg::ENERGY_W-1:0]      i_root,
    output ctepm_pkg::t_ctl                     o_ctl,
    output logic signed [SAMPLE_WIDTH+2:0]      o_x,
    output logic signed [SAMPLE_WIDTH+2:0]      o_y,
    output logic [ctepm_pkg::ACC_W-1:0]         o_acc,
    output logic [ctepm_pkg::ENERGY_W-1:0]      o_energy,
    output logic [ctepm_pkg::ENERGY_W-1:0]      o_rem,
    output logic [ctepm_pkg::ENERGY_W-1:0]      o_root
);
    import ctepm_pkg::*;

    localparam int XW       = SAMPLE_WIDTH + 3;
    localparam bit ROT_ON   = (IDX < CORDIC_STAGES);
    localparam bit SQRT_ON  = (IDX < SQRT_STEPS);
    localparam int SQRT_SH  = SQRT_ON ? (ENERGY_W - 2 - 2 * IDX) : 0;
    localparam logic [ACC_W-1:0]    ANGLE    = ATAN_TAB[IDX];
    localparam logic [ENERGY_W:0]   SQRT_BIT = (ENERGY_W + 1)'(1) << SQRT_SH;

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic [ENERGY_W:0]    trial;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic [ACC_W-1:0]     n_acc;
    logic [ENERGY_W-1:0]  n_rem;
    logic [ENERGY_W-1:0]  n_root;

    assign xs    = i_x >>> IDX;
    assign ys    = i_y >>> IDX;
    assign trial = {1'b0, i_root} + SQRT_BIT;

    always_comb begin
        n_x   = i_x;
        n_y   = i_y;
        n_acc = i_acc;
        if (ROT_ON) begin
            // Rotate towards the positive real axis.
            if (!i_y[XW-1]) begin
                n_x   = i_x + ys;
                n_y   = i_y - xs;
                n_acc = i_acc + ANGLE;
            end else begin
                n_x   = i_x - ys;
                n_y   = i_y + xs;
                n_acc = i_acc - ANGLE;
            end
        end
    end

    always_comb begin
        n_rem  = i_rem;
        n_root = i_root;
        if (SQRT_ON) begin
            if ({1'b0, i_rem} >= trial) begin
                n_rem  = i_rem - trial[ENERGY_W-1:0];
                n_root = (i_root >> 1) + SQRT_BIT[ENERGY_W-1:0];
            end else begin
                n_root = i_root >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.valid <= 1'b0;
        end else if (i_en) begin
            o_ctl    <= i_ctl;
            o_x      <= n_x;
            o_y      <= n_y;
            o_acc    <= n_acc;
            o_energy <= i_energy;
            o_rem    <= n_rem;
            o_root   <= n_root;
        end
    end

endmodule

`default_nettype wire

### hdl/ctepm_back.sv
// Result assembly: rounds the root and the angle, applies the output mode and packs the transfer.
// Depends on ctepm_pkg. Purely combinational; feeds the output register in the top level.
`default_nettype none

module ctepm_back (
    input  ctepm_pkg::t_ctl                     i_ctl,
    input  wire  [ctepm_pkg::ACC_W-1:0]         i_acc,
    input  wire  [ctepm_pkg::ENERGY_W-1:0]      i_energy,
    input  wire  [ctepm_pkg::ENERGY_W-1:0]      i_rem,
    input  wire  [ctepm_pkg::ENERGY_W-1:0]      i_root,
    output logic [ctepm_pkg::OUT_TDATA_W-1:0]   o_data
);
    import ctepm_pkg::*;

    logic [ACC_W-1:0]    acc_rnd;
    logic [MAG_W-1:0]    mag;
    logic [PHASE_W-1:0]  phase;
    logic [ENERGY_W-1:0] energy_sel;
    logic [MAG_W-1:0]    mag_sel;
    logic [PHASE_W-1:0]  phase_sel;

    // Round up when the remainder exceeds the root.
    assign mag     = i_root[MAG_W-1:0] + MAG_W'(i_rem > i_root);
    assign acc_rnd = i_acc + ANGLE_ROUND_HALF;
    assign phase   = i_ctl.zero ? '0 : acc_rnd[ACC_W-1 -: PHASE_W];

    always_comb begin
        energy_sel = '0;
        mag_sel    = '0;
        phase_sel  = '0;
        case (i_ctl.mode)
            MODE_ENERGY: begin
                energy_sel = i_energy;
            end
            MODE_PHASE: begin
                phase_sel = phase;
            end
            MODE_BOTH: begin
                energy_sel = i_energy;
                phase_sel  = phase;
            end
            MODE_MAGNITUDE: begin
                mag_sel = mag;
            end
            default: begin
                energy_sel = '0;
            end
        endcase
    end

    assign o_data = {phase_sel, mag_sel, energy_sel};

endmodule

`default_nettype wire

### hdl/complex_to_energy_phase_magnitude.sv
// Complex bin to energy / phase / magnitude converter, top level.
// Depends on ctepm_pkg, ctepm_front, ctepm_cell and ctepm_back.
//
// Input stream: one complex bin per transfer, real part in the low SAMPLE_WIDTH bits of
// s_axis_tdata, imaginary part above it, frame end on s_axis_tlast. Output stream: one
// result per bin on m_axis_tdata (energy Q2.30, magnitude Q1.15, phase as binary angle with
// 32768 for pi), frame end copied to m_axis_tlast. Fields the mode does not select are zero.
// The mode register is written through i_cfg_we / i_cfg_wdata; the user must write it only while the
// stream is idle, which the block does not enforce; each bin picks up the mode when it enters.
// Pipeline: two front stages (squares, then energy scaling and quadrant fold), one cell per
// CORDIC micro-rotation / square-root digit, then the output register.
// Throughput: one bin per cycle; the cell chain advances every cycle while the skid slot is
// empty. When the receiver stalls, the output register holds its result, the next result
// lands in the skid slot and s_axis_tready drops once the slot is full, until the slot drains.
// Reset (synchronous, active low) empties the pipeline and sets the mode to energy.
`default_nettype none

module complex_to_energy_phase_magnitude #(
    parameter int SAMPLE_WIDTH  = ctepm_pkg::DEF_SAMPLE_WIDTH,
    parameter int CORDIC_STAGES = ctepm_pkg::DEF_CORDIC_STAGES
) (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    // [SAMPLE_WIDTH-1:0] sample_re, [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] sample_im, zero fill
    input  wire  [((2*SAMPLE_WIDTH+7)/8)*8-1:0]        i_s_axis_tdata,
    input  wire                                        i_s_axis_tvalid,
    input  wire                                        i_s_axis_tlast,
    output logic                                       o_s_axis_tready,
    // [31:0] energy_out, [47:32] magnitude_out, [63:48] phase_out
    output logic [ctepm_pkg::OUT_TDATA_W-1:0]          o_m_axis_tdata,
    output logic                                       o_m_axis_tvalid,
    output logic                                       o_m_axis_tlast,
    input  wire                                        i_m_axis_tready,
    input  wire                                        i_cfg_we,
    input  wire  [1:0]                                 i_cfg_wdata
);
    import ctepm_pkg::*;

    localparam int XW      = SAMPLE_WIDTH + 3;
    localparam int N_CELLS = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

    t_mode                      r_mode;
    logic                       en;

    t_ctl                       ctl_c    [N_CELLS+1];
    logic signed [XW-1:0]       x_c      [N_CELLS+1];
    logic signed [XW-1:0]       y_c      [N_CELLS+1];
    logic [ACC_W-1:0]           acc_c    [N_CELLS+1];
    logic [ENERGY_W-1:0]        energy_c [N_CELLS+1];
    logic [ENERGY_W-1:0]        rem_c    [N_CELLS+1];
    logic [ENERGY_W-1:0]        root_c   [N_CELLS+1];

    logic [OUT_TDATA_W-1:0]     bk_data;
    logic                       bk_valid;

    logic                       r_out_valid;
    logic [OUT_TDATA_W-1:0]     r_out_data;
    logic                       r_out_last;
    logic                       r_skid_valid;
    logic [OUT_TDATA_W-1:0]     r_skid_data;
    logic                       r_skid_last;
    logic                       n_out_valid;
    logic                       n_skid_valid;
    logic                       load_out;
    logic                       load_skid;
    logic                       drain_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENERGY;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_wdata);
        end
    end

    // The whole chain moves in lockstep while the skid slot can absorb a result.
    assign en              = !r_skid_valid;
    assign o_s_axis_tready = en;

    ctepm_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_s_axis_tvalid),
        .i_re     (i_s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_im     (i_s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .i_last   (i_s_axis_tlast),
        .i_mode   (r_mode),
        .o_ctl    (ctl_c[0]),
        .o_x      (x_c[0]),
        .o_y      (y_c[0]),
        .o_acc    (acc_c[0]),
        .o_energy (energy_c[0])
    );

    assign rem_c[0]  = energy_c[0];
    assign root_c[0] = '0;

    generate
        for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
            ctepm_cell #(
                .SAMPLE_WIDTH  (SAMPLE_WIDTH),
                .CORDIC_STAGES (CORDIC_STAGES),
                .IDX           (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (en),
                .i_ctl    (ctl_c[g]),
                .i_x      (x_c[g]),
                .i_y      (y_c[g]),
                .i_acc    (acc_c[g]),
                .i_energy (energy_c[g]),
                .i_rem    (rem_c[g]),
                .i_root   (root_c[g]),
                .o_ctl    (ctl_c[g+1]),
                .o_x      (x_c[g+1]),
                .o_y      (y_c[g+1]),
                .o_acc    (acc_c[g+1]),
                .o_energy (energy_c[g+1]),
                .o_rem    (rem_c[g+1]),
                .o_root   (root_c[g+1])
            );
        end
    endgenerate

    ctepm_back u_back (
        .i_ctl    (ctl_c[N_CELLS]),
        .i_acc    (acc_c[N_CELLS]),
        .i_energy (energy_c[N_CELLS]),
        .i_rem    (rem_c[N_CELLS]),
        .i_root   (root_c[N_CELLS]),
        .o_data   (bk_data)
    );

    assign bk_valid = ctl_c[N_CELLS].valid && en;

    // Output register with one skid slot behind it.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        load_out     = 1'b0;
        load_skid    = 1'b0;
        drain_skid   = 1'b0;
        if (r_skid_valid) begin
            if (i_m_axis_tready) begin
                drain_skid   = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (bk_valid) begin
            if (!r_out_valid || i_m_axis_tready) begin
                load_out    = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                load_skid    = 1'b1;
                n_skid_valid = 1'b1;
            end
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain_skid) begin
            r_out_data <= r_skid_data;
            r_out_last <= r_skid_last;
        end else if (load_out) begin
            r_out_data <= bk_data;
            r_out_last <= ctl_c[N_CELLS].last;
        end
        if (load_skid) begin
            r_skid_data <= bk_data;
            r_skid_last <= ctl_c[N_CELLS].last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

### hdl/ctepm_checker.sv
// Port-level checks for the converter top level, attached by the bind below.
// Depends on ctepm_pkg for the result field widths.
`default_nettype none

module ctepm_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tready,
    input  wire                                 i_m_tvalid,
    input  wire                                 i_m_tready,
    input  wire                                 i_m_tlast,
    input  wire  [ctepm_pkg::OUT_TDATA_W-1:0]   i_m_tdata
);
    import ctepm_pkg::*;

    logic [ENERGY_W-1:0] chk_energy;
    logic [MAG_W-1:0]    chk_mag;
    logic [PHASE_W-1:0]  chk_phase;

    assign chk_energy = i_m_tdata[ENERGY_W-1:0];
    assign chk_mag    = i_m_tdata[ENERGY_W +: MAG_W];
    assign chk_phase  = i_m_tdata[ENERGY_W+MAG_W +: PHASE_W];

    // Reset empties the output register.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))
        else $error("stalled result changed");

    // With nothing waiting at the output the skid slot is empty, so input is taken.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_tvalid |-> i_s_tready)
        else $error("input stalled with empty output");

    // Magnitude mode excludes the other two fields.
    a_mode_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (chk_mag != '0) |-> (chk_energy == '0) && (chk_phase == '0))
        else $error("magnitude shown together with energy or phase");

endmodule

bind complex_to_energy_phase_magnitude ctepm_checker u_ctepm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tlast  (o_m_axis_tlast),
    .i_m_tdata  (o_m_axis_tdata)
);

`default_nettype wire
